// ===== hdl/cbm_pkg.sv =====
// shared types and constants for the cartridge bank mapper
package cbm_pkg;

  localparam int unsigned MaxRamBanks  = 16;
  localparam int unsigned RamBankBytes = 8192;
  localparam int unsigned RomBankBytes = 16384;

  localparam int unsigned RamAddrW = $clog2(MaxRamBanks * RamBankBytes);
  localparam int unsigned BankW    = 9;
  localparam int unsigned CountW   = 10;
  localparam int unsigned StepW    = $clog2(BankW + 1);

  typedef enum logic [1:0] {
    CMD_ROM_RD = 2'd0,
    CMD_REG_WR = 2'd1,
    CMD_RAM_RD = 2'd2,
    CMD_RAM_WR = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_MBC1   = 3'd1,
    KIND_MBC2   = 3'd2,
    KIND_ROMRAM = 3'd3,
    KIND_MBC3   = 3'd4,
    KIND_MBC5   = 3'd5,
    KIND_HUC1   = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    CFG_KIND      = 3'd0,
    CFG_ROM_COUNT = 3'd1,
    CFG_RAM_COUNT = 3'd2,
    CFG_RAM_SIZE  = 3'd3,
    CFG_NARROW    = 3'd4
  } cfg_e;

  typedef struct packed {
    logic              start;
    logic [BankW-1:0]  dividend;
    logic [CountW-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [BankW-1:0] rem;
  } mod_rsp_t;

endpackage

// ===== hdl/cbm_mod_unit.sv =====
// iterative restoring remainder unit, one dividend bit per cycle
module cbm_mod_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cbm_pkg::mod_req_t req_i,
  output cbm_pkg::mod_rsp_t rsp_o
);
  import cbm_pkg::*;

  logic [StepW-1:0]  cnt_q;
  logic [BankW-1:0]  dvd_q;
  logic [CountW-1:0] div_q;
  logic [CountW-1:0] rem_q;
  logic              done_q;
  logic [CountW:0]   shifted;
  logic [CountW:0]   diff;

  assign shifted = {rem_q, dvd_q[BankW-1]};
  assign diff    = shifted - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
      dvd_q  <= '0;
      div_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= StepW'(BankW);
        dvd_q <= req_i.dividend;
        div_q <= req_i.divisor;
        rem_q <= '0;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        dvd_q <= {dvd_q[BankW-2:0], 1'b0};
        if (shifted >= {1'b0, div_q}) begin
          rem_q <= diff[CountW-1:0];
        end else begin
          rem_q <= shifted[CountW-1:0];
        end
        done_q <= (cnt_q == StepW'(1));
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q[BankW-1:0];

endmodule

// ===== hdl/cbm_ram.sv =====
// single port cartridge ram with registered read
module cbm_ram (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [cbm_pkg::RamAddrW-1:0] addr_i,
  input  logic [7:0]                   wdata_i,
  output logic [7:0]                   rdata_o
);
  import cbm_pkg::*;

  logic [7:0] mem_q [MaxRamBanks*RamBankBytes];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== hdl/cartridge_bank_mapper.sv =====
// cartridge bank mapper top level: sequencer, bank registers and rtc registers
//
// channel   direction  handshake               ports
// command   in         start_i & !busy_o       cmd_i, address_i, write_data_i
// result    out        done_o (one cycle)      read_data_o, rom_lookup_o, rom_address_o
// config    in         cfg_we_i                cfg_index_i, cfg_data_i
//
// a word goes through S_DECODE from accept to result without a bank remainder and through S_MOD with one;
// an mbc1 register write in advanced mode makes two remainder passes, upper bank then lower bank
// ram accesses add S_MEM, and S_MEMRD for reads, on the single ram port
// after reset the ram is filled with 0xff while busy_o is high
// results cannot be stalled: done_o is high for exactly one cycle
module cartridge_bank_mapper (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  output logic        done_o,
  output logic [7:0]  read_data_o,
  output logic        rom_lookup_o,
  output logic [22:0] rom_address_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i
);
  import cbm_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_MOD, S_MEM, S_MEMRD
  } state_e;

  typedef enum logic [2:0] {
    P_ROM, P_MBC1_UP, P_MBC1_LO, P_NZ, P_KEEP, P_RAM
  } post_e;

  typedef enum logic [2:0] {
    RP_NONE, RP_FIXED, RP_CLOCK, RP_DIRECT, RP_BANKED, RP_MBC2
  } rpath_e;

  state_e state_q;
  post_e  post_q;

  logic [2:0]  kind_q;
  logic [9:0]  rom_cnt_q;
  logic [4:0]  ram_cnt_q;
  logic [2:0]  size_q;
  logic        narrow_q;

  logic        ram_en_q, adv_q;
  logic [8:0]  upper_q, lower_q;
  logic [7:0]  ram_sel_q;
  logic [4:0]  lbb_q;
  logic [1:0]  hbb_q;
  logic [7:0]  latch_prev_q;
  logic [7:0]  clk_live_q [5];
  logic [7:0]  clk_latch_q [5];

  logic [1:0]  cmd_q;
  logic [15:0] addr_q;
  logic [7:0]  wdata_q;
  logic [RamAddrW-1:0] off_q;
  logic [RamAddrW-1:0] clr_q;

  logic        done_q, look_q;
  logic [7:0]  rd_q;
  logic [22:0] raddr_q;

  mod_req_t    mreq_q;
  mod_rsp_t    mrsp;

  logic        ram_we;
  logic [RamAddrW-1:0] ram_addr;
  logic [7:0]  ram_wdata, ram_rdata;

  logic        present;
  logic [4:0]  nb;
  rpath_e      rp;
  logic [RamAddrW-1:0] rp_off;
  logic [2:0]  clk_idx;
  logic        is_wr;
  logic [8:0]  rem_one, rem_keep, rem_nz;

  logic        ram_en_n, adv_n;
  logic [4:0]  lbb_n;
  logic [1:0]  hbb_n;
  logic [8:0]  mbc1_bank_n;
  logic [8:0]  mbc1_low;
  logic [3:0]  v4;

  assign is_wr   = (cmd_q == CMD_RAM_WR);
  assign present = (ram_cnt_q != '0);
  assign nb      = (ram_cnt_q == '0) ? 5'd1 :
                   (ram_cnt_q > 5'(MaxRamBanks)) ? 5'(MaxRamBanks) : ram_cnt_q;
  assign clk_idx = ram_sel_q[2:0];
  assign v4      = wdata_q[3:0];

  // ram path selection
  always_comb begin
    rp     = RP_NONE;
    rp_off = {4'd0, addr_q[12:0]};
    case (kind_e'(kind_q))
      KIND_ROMRAM: if (present) rp = RP_DIRECT;
      KIND_MBC1, KIND_HUC1: begin
        if (kind_q == KIND_HUC1 && ram_en_q) begin
          rp = RP_FIXED;
        end else if ((kind_q == KIND_HUC1 || ram_en_q) && present) begin
          case (size_q)
            3'd0: rp = RP_NONE;
            3'd1: begin
              rp     = RP_DIRECT;
              rp_off = {6'd0, addr_q[10:0]};
            end
            3'd2: rp = RP_DIRECT;
            default: rp = RP_BANKED;
          endcase
        end
      end
      KIND_MBC2: if (ram_en_q) rp = RP_MBC2;
      KIND_MBC3: begin
        if (ram_en_q) begin
          if (ram_sel_q < 8'd4) begin
            if (present) rp = RP_BANKED;
          end else if (ram_sel_q >= 8'h08 && ram_sel_q <= 8'h0C) begin
            rp = RP_CLOCK;
          end
        end
      end
      KIND_MBC5: begin
        if (ram_en_q && present) begin
          rp = (size_q <= 3'd1) ? RP_DIRECT : RP_BANKED;
        end
      end
      default: rp = RP_NONE;
    endcase
  end

  // mbc1 register update preview
  always_comb begin
    ram_en_n = ram_en_q;
    adv_n    = adv_q;
    lbb_n    = lbb_q;
    hbb_n    = hbb_q;
    case (addr_q[15:13])
      3'd0: ram_en_n = (wdata_q[3:0] == 4'hA);
      3'd1: lbb_n = (wdata_q[4:0] == '0) ? 5'd1 : wdata_q[4:0];
      3'd2: hbb_n = wdata_q[1:0];
      3'd3: adv_n = wdata_q[0];
      default: ;
    endcase
    mbc1_bank_n = narrow_q ? {3'd0, hbb_n, lbb_n[3:0]} : {2'd0, hbb_n, lbb_n};
    mbc1_low    = narrow_q ? {3'd0, hbb_q, 4'd0} : {2'd0, hbb_q, 5'd0};
  end

  assign rem_keep = mrsp.rem;
  assign rem_one  = (rom_cnt_q == '0) ? 9'd0 : mrsp.rem;
  assign rem_nz   = (rem_one == '0) ? 9'd1 : rem_one;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q    <= KIND_NONE;
      rom_cnt_q <= 10'd2;
      ram_cnt_q <= '0;
      size_q    <= '0;
      narrow_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_index_i))
        CFG_KIND:      kind_q    <= cfg_data_i[2:0];
        CFG_ROM_COUNT: rom_cnt_q <= cfg_data_i;
        CFG_RAM_COUNT: ram_cnt_q <= cfg_data_i[4:0];
        CFG_RAM_SIZE:  size_q    <= cfg_data_i[2:0];
        CFG_NARROW:    narrow_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      post_q       <= P_ROM;
      clr_q        <= '0;
      ram_en_q     <= 1'b0;
      adv_q        <= 1'b0;
      upper_q      <= 9'd1;
      lower_q      <= '0;
      ram_sel_q    <= '0;
      lbb_q        <= 5'd1;
      hbb_q        <= '0;
      latch_prev_q <= 8'hFF;
      for (int i = 0; i < 5; i++) begin
        clk_live_q[i]  <= '0;
        clk_latch_q[i] <= '0;
      end
      cmd_q   <= '0;
      addr_q  <= '0;
      wdata_q <= '0;
      off_q   <= '0;
      done_q  <= 1'b0;
      look_q  <= 1'b0;
      rd_q    <= 8'hFF;
      raddr_q <= '0;
      mreq_q  <= '0;
    end else begin
      done_q       <= 1'b0;
      mreq_q.start <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (&clr_q) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start_i) begin
            cmd_q   <= cmd_i;
            addr_q  <= address_i;
            wdata_q <= write_data_i;
            rd_q    <= 8'hFF;
            look_q  <= 1'b0;
            raddr_q <= '0;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          state_q         <= S_IDLE;
          done_q          <= 1'b1;
          mreq_q.divisor  <= rom_cnt_q;
          case (cmd_e'(cmd_q))
            CMD_ROM_RD: begin
              if (!addr_q[15]) begin
                mreq_q.start    <= 1'b1;
                mreq_q.dividend <= addr_q[14] ? upper_q : lower_q;
                post_q          <= P_ROM;
                done_q          <= 1'b0;
                state_q         <= S_MOD;
              end
            end
            CMD_REG_WR: begin
              case (kind_e'(kind_q))
                KIND_MBC1: begin
                  ram_en_q        <= ram_en_n;
                  adv_q           <= adv_n;
                  lbb_q           <= lbb_n;
                  hbb_q           <= hbb_n;
                  ram_sel_q       <= adv_n ? {6'd0, hbb_n} : 8'd0;
                  if (!adv_n) lower_q <= '0;
                  mreq_q.start    <= 1'b1;
                  mreq_q.dividend <= mbc1_bank_n;
                  post_q          <= P_MBC1_UP;
                  done_q          <= 1'b0;
                  state_q         <= S_MOD;
                end
                KIND_MBC2: begin
                  if (addr_q[15:14] == 2'd0) begin
                    if (!addr_q[8]) begin
                      ram_en_q <= (v4 == 4'hA);
                    end else begin
                      mreq_q.start    <= 1'b1;
                      mreq_q.dividend <= (v4 == '0) ? 9'd1 : {5'd0, v4};
                      post_q          <= P_NZ;
                      done_q          <= 1'b0;
                      state_q         <= S_MOD;
                    end
                  end
                end
                KIND_MBC3: begin
                  case (addr_q[15:13])
                    3'd0: ram_en_q <= (v4 == 4'hA);
                    3'd1: begin
                      mreq_q.start    <= 1'b1;
                      mreq_q.dividend <= (wdata_q[6:0] == '0) ? 9'd1 : {2'd0, wdata_q[6:0]};
                      post_q          <= P_NZ;
                      done_q          <= 1'b0;
                      state_q         <= S_MOD;
                    end
                    3'd2: ram_sel_q <= wdata_q;
                    3'd3: begin
                      if (latch_prev_q == 8'h00 && wdata_q == 8'h01) begin
                        for (int i = 0; i < 5; i++) clk_latch_q[i] <= clk_live_q[i];
                      end
                      latch_prev_q <= wdata_q;
                    end
                    default: ;
                  endcase
                end
                KIND_MBC5: begin
                  if (addr_q[15:13] == 3'd0) begin
                    ram_en_q <= (v4 == 4'hA);
                  end else if (addr_q[15:12] == 4'h2 || addr_q[15:12] == 4'h3) begin
                    mreq_q.start    <= 1'b1;
                    mreq_q.dividend <= addr_q[12] ? {wdata_q[0], upper_q[7:0]}
                                                  : {upper_q[8], wdata_q};
                    post_q          <= P_KEEP;
                    done_q          <= 1'b0;
                    state_q         <= S_MOD;
                  end else if (addr_q[15:13] == 3'd2) begin
                    ram_sel_q <= {4'd0, v4};
                  end
                end
                KIND_HUC1: begin
                  case (addr_q[15:13])
                    3'd0: ram_en_q <= (v4 == 4'hE);
                    3'd1: begin
                      mreq_q.start    <= 1'b1;
                      mreq_q.dividend <= (wdata_q[5:0] == '0) ? 9'd1 : {3'd0, wdata_q[5:0]};
                      post_q          <= P_NZ;
                      done_q          <= 1'b0;
                      state_q         <= S_MOD;
                    end
                    3'd2: ram_sel_q <= {6'd0, wdata_q[1:0]};
                    default: ;
                  endcase
                end
                default: ;
              endcase
            end
            default: begin
              case (rp)
                RP_FIXED: if (!is_wr) rd_q <= 8'hC0;
                RP_CLOCK: begin
                  if (is_wr) begin
                    clk_live_q[clk_idx]  <= wdata_q;
                    clk_latch_q[clk_idx] <= wdata_q;
                  end else begin
                    rd_q <= clk_latch_q[clk_idx];
                  end
                end
                RP_DIRECT: begin
                  off_q   <= rp_off;
                  done_q  <= 1'b0;
                  state_q <= S_MEM;
                end
                RP_MBC2: begin
                  off_q   <= {8'd0, addr_q[8:0]};
                  done_q  <= 1'b0;
                  state_q <= S_MEM;
                end
                RP_BANKED: begin
                  mreq_q.start    <= 1'b1;
                  mreq_q.dividend <= {1'b0, ram_sel_q};
                  mreq_q.divisor  <= {5'd0, nb};
                  post_q          <= P_RAM;
                  done_q          <= 1'b0;
                  state_q         <= S_MOD;
                end
                default: ;
              endcase
            end
          endcase
        end
        S_MOD: begin
          if (mrsp.done) begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
            case (post_q)
              P_ROM: begin
                look_q  <= 1'b1;
                raddr_q <= {rem_one, addr_q[13:0]};
              end
              P_MBC1_UP: begin
                upper_q <= (rem_keep == '0) ? 9'd1 : rem_keep;
                if (adv_q) begin
                  mreq_q.start    <= 1'b1;
                  mreq_q.dividend <= mbc1_low;
                  post_q          <= P_MBC1_LO;
                  done_q          <= 1'b0;
                  state_q         <= S_MOD;
                end
              end
              P_MBC1_LO: lower_q <= rem_one;
              P_NZ:      upper_q <= rem_nz;
              P_KEEP:    upper_q <= rem_keep;
              P_RAM: begin
                off_q   <= {mrsp.rem[3:0], addr_q[12:0]};
                done_q  <= 1'b0;
                state_q <= S_MEM;
              end
              default: ;
            endcase
          end
        end
        S_MEM: begin
          if (is_wr) begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
          end else begin
            state_q <= S_MEMRD;
          end
        end
        S_MEMRD: begin
          rd_q    <= (rp == RP_MBC2) ? {4'hF, ram_rdata[3:0]} : ram_rdata;
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign ram_we    = (state_q == S_CLEAR) || (state_q == S_MEM && is_wr);
  assign ram_addr  = (state_q == S_CLEAR) ? clr_q : off_q;
  assign ram_wdata = (state_q == S_CLEAR) ? 8'hFF :
                     (rp == RP_MBC2) ? {4'hF, v4} : wdata_q;

  cbm_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq_q),
    .rsp_o  (mrsp)
  );

  cbm_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign read_data_o   = rd_q;
  assign rom_lookup_o  = look_q;
  assign rom_address_o = raddr_q;

endmodule

// ===== hdl/cbm_checker.sv =====
// port level checks for the cartridge bank mapper
module cbm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [7:0]  read_data_o,
  input logic        rom_lookup_o,
  input logic [22:0] rom_address_o
);

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("busy not raised after accept");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result word longer than one cycle");

  a_no_lookup_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rom_lookup_o) |-> (rom_address_o == 23'd0))
    else $error("rom address set without lookup");

  a_lookup_ff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rom_lookup_o) |-> (read_data_o == 8'hFF))
    else $error("rom lookup with data byte");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .read_data_o   (read_data_o),
  .rom_lookup_o  (rom_lookup_o),
  .rom_address_o (rom_address_o)
);

// ===== bench/testbench.sv =====
// self-checking testbench for the cartridge bank mapper
`timescale 1ns / 100ps

module testbench;
  import cbm_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned SettleCycles = 32;
  localparam int unsigned CartBytes = MaxRamBanks * RamBankBytes;

  typedef struct {
    logic [7:0]  read_data;
    logic        rom_lookup;
    logic [22:0] rom_address;
  } bus_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  cmd_i = '0;
  logic [15:0] address_i = '0;
  logic [7:0]  write_data_i = '0;
  logic        done_o;
  logic [7:0]  read_data_o;
  logic        rom_lookup_o;
  logic [22:0] rom_address_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [9:0]  cfg_data_i = '0;

  cartridge_bank_mapper u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cmd_i        (cmd_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .done_o       (done_o),
    .read_data_o  (read_data_o),
    .rom_lookup_o (rom_lookup_o),
    .rom_address_o(rom_address_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // mapper model state
  int unsigned kind_q, rom_count_q, ram_count_q, size_code_q, narrow_q;
  bit          ram_on_q, advanced_q;
  int unsigned upper_q, lower_q, ram_sel_q, low_bits_q, high_bits_q, latch_prev_q;
  byte unsigned clock_live_q[5], clock_held_q[5];
  byte unsigned cart_mem[CartBytes];

  bus_word_t   expected_words[$];
  bus_word_t   got_word;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned settings_used = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int unsigned ram_banks();
    return (ram_count_q > MaxRamBanks) ? MaxRamBanks : ram_count_q;
  endfunction

  function automatic int unsigned mod_floor(int unsigned b);
    return (rom_count_q == 0) ? 0 : b % rom_count_q;
  endfunction

  function automatic int unsigned mod_keep(int unsigned b);
    return (rom_count_q == 0) ? b : b % rom_count_q;
  endfunction

  function automatic int unsigned banked_offset(int unsigned a);
    int unsigned nb;
    nb = ram_banks();
    if (nb == 0) nb = 1;
    return (ram_sel_q % nb) * RamBankBytes + (a & 32'h1FFF);
  endfunction

  function automatic bit sized_offset(int unsigned a, output int unsigned off);
    off = 0;
    if (size_code_q == 0) return 1'b0;
    if (size_code_q == 1) off = a & 32'h7FF;
    else if (size_code_q == 2) off = a & 32'h1FFF;
    else off = banked_offset(a);
    return 1'b1;
  endfunction

  function automatic int unsigned nonzero_bank(int unsigned b);
    if (b == 0) b = 1;
    b = mod_floor(b);
    return (b == 0) ? 1 : b;
  endfunction

  function automatic void update_bank_regs(int unsigned a, int unsigned v);
    int unsigned mask, shift, bank;
    case (kind_q)
      KIND_MBC1: begin
        mask = narrow_q ? 32'h0F : 32'h1F;
        shift = narrow_q ? 4 : 5;
        case (a & 32'hE000)
          32'h0000: ram_on_q = ((v & 32'h0F) == 32'h0A);
          32'h2000: begin
            low_bits_q = v & 32'h1F;
            if (low_bits_q == 0) low_bits_q = 1;
          end
          32'h4000: high_bits_q = v & 32'h03;
          32'h6000: advanced_q = (v & 1) != 0;
          default: ;
        endcase
        bank = mod_keep((low_bits_q & mask) | (high_bits_q << shift));
        upper_q = (bank == 0) ? 1 : bank;
        if (advanced_q) begin
          lower_q = mod_floor(high_bits_q << shift);
          ram_sel_q = high_bits_q;
        end else begin
          lower_q = 0;
          ram_sel_q = 0;
        end
      end
      KIND_MBC2: begin
        if (a <= 32'h3FFF) begin
          v = v & 32'h0F;
          if ((a & 32'h100) == 0) ram_on_q = (v == 32'h0A);
          else upper_q = nonzero_bank(v);
        end
      end
      KIND_MBC3: begin
        case (a & 32'hE000)
          32'h0000: ram_on_q = ((v & 32'h0F) == 32'h0A);
          32'h2000: upper_q = nonzero_bank(v & 32'h7F);
          32'h4000: ram_sel_q = v;
          32'h6000: begin
            if (latch_prev_q == 0 && v == 1) clock_held_q = clock_live_q;
            latch_prev_q = v;
          end
          default: ;
        endcase
      end
      KIND_MBC5: begin
        if (a <= 32'h1FFF) ram_on_q = ((v & 32'h0F) == 32'h0A);
        else if (a <= 32'h2FFF) upper_q = mod_keep((upper_q & 32'h100) | v);
        else if (a <= 32'h3FFF) upper_q = mod_keep((upper_q & 32'hFF) | ((v & 1) << 8));
        else if (a <= 32'h5FFF) ram_sel_q = v & 32'h0F;
      end
      KIND_HUC1: begin
        case (a & 32'hE000)
          32'h0000: ram_on_q = ((v & 32'h0F) == 32'h0E);
          32'h2000: upper_q = nonzero_bank(v & 32'h3F);
          32'h4000: ram_sel_q = v & 32'h03;
          default: ;
        endcase
      end
      default: ;
    endcase
  endfunction

  function automatic int unsigned cart_ram_access(int unsigned a, bit wr, int unsigned v);
    bit          present, hit;
    int unsigned off, r;
    present = ram_banks() != 0;
    off = 0;
    hit = 1'b0;
    case (kind_q)
      KIND_ROMRAM: if (present) begin
        off = a & 32'h1FFF;
        hit = 1'b1;
      end
      KIND_MBC1: if (ram_on_q && present) hit = sized_offset(a, off);
      KIND_MBC2: if (ram_on_q) begin
        off = a & 32'h1FF;
        if (wr) begin
          cart_mem[off] = 8'(32'hF0 | (v & 32'h0F));
          return 32'hFF;
        end
        return 32'hF0 | (32'(cart_mem[off]) & 32'h0F);
      end
      KIND_MBC3: if (ram_on_q) begin
        if (ram_sel_q < 4) begin
          if (present) begin
            off = banked_offset(a);
            hit = 1'b1;
          end
        end else if (ram_sel_q >= 32'h08 && ram_sel_q <= 32'h0C) begin
          r = ram_sel_q - 32'h08;
          if (wr) begin
            clock_live_q[r] = 8'(v);
            clock_held_q[r] = 8'(v);
            return 32'hFF;
          end
          return 32'(clock_held_q[r]);
        end
      end
      KIND_MBC5: if (ram_on_q && present) begin
        off = (size_code_q <= 1) ? (a & 32'h1FFF) : banked_offset(a);
        hit = 1'b1;
      end
      KIND_HUC1: begin
        if (ram_on_q) return wr ? 32'hFF : 32'hC0;
        if (present) hit = sized_offset(a, off);
      end
      default: ;
    endcase
    if (!hit || off >= CartBytes) return 32'hFF;
    if (wr) begin
      cart_mem[off] = 8'(v);
      return 32'hFF;
    end
    return 32'(cart_mem[off]);
  endfunction

  function automatic bus_word_t predict_access(cmd_e c, int unsigned a, int unsigned v);
    bus_word_t w;
    w.read_data = 8'hFF;
    w.rom_lookup = 1'b0;
    w.rom_address = '0;
    case (c)
      CMD_ROM_RD: begin
        if (a < 32'h4000) begin
          w.rom_lookup = 1'b1;
          w.rom_address = 23'(mod_floor(lower_q) * RomBankBytes + a);
        end else if (a < 32'h8000) begin
          w.rom_lookup = 1'b1;
          w.rom_address = 23'(mod_floor(upper_q) * RomBankBytes + (a & 32'h3FFF));
        end
      end
      CMD_REG_WR: update_bank_regs(a, v);
      CMD_RAM_RD: w.read_data = 8'(cart_ram_access(a, 1'b0, 0));
      default: void'(cart_ram_access(a, 1'b1, v));
    endcase
    return w;
  endfunction

  function automatic void reset_model();
    kind_q = 0; rom_count_q = 2; ram_count_q = 0; size_code_q = 0; narrow_q = 0;
    ram_on_q = 0; advanced_q = 0;
    upper_q = 1; lower_q = 0; ram_sel_q = 0; low_bits_q = 1; high_bits_q = 0;
    latch_prev_q = 32'hFF;
    foreach (clock_live_q[i]) begin
      clock_live_q[i] = 0;
      clock_held_q[i] = 0;
    end
    foreach (cart_mem[i]) cart_mem[i] = 8'hFF;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: read_data %h rom_lookup %b rom_address %h",
               read_data_o, rom_lookup_o, rom_address_o);
        mismatches++;
      end else begin
        got_word = expected_words.pop_front();
        words_checked++;
        if (read_data_o !== got_word.read_data) begin
          $error("read_data expected %h actual %h", got_word.read_data, read_data_o);
          mismatches++;
        end
        if (rom_lookup_o !== got_word.rom_lookup) begin
          $error("rom_lookup expected %b actual %b", got_word.rom_lookup, rom_lookup_o);
          mismatches++;
        end
        if (rom_address_o !== got_word.rom_address) begin
          $error("rom_address expected %h actual %h", got_word.rom_address, rom_address_o);
          mismatches++;
        end
      end
    end
  end

  task automatic send_access(cmd_e c, logic [15:0] a, logic [7:0] v, int unsigned idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i <= c;
    address_i <= a;
    write_data_i <= v;
    do @(posedge clk_i); while (busy_o);
    expected_words.insert(expected_words.size(), predict_access(c, 32'(a), 32'(v)));
    words_sent++;
  endtask

  task automatic drain_words();
    start_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apply_setting(int unsigned kind, int unsigned rom_cnt, int unsigned ram_cnt,
                               int unsigned size_code, int unsigned narrow);
    int unsigned vals[5];
    vals = '{kind, rom_cnt, ram_cnt, size_code, narrow};
    drain_words();
    for (int i = 0; i < 5; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= i[2:0];
      cfg_data_i <= vals[i][9:0];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    kind_q = kind & 7;
    rom_count_q = rom_cnt & 32'h3FF;
    ram_count_q = ram_cnt & 32'h1F;
    size_code_q = size_code & 7;
    narrow_q = narrow & 1;
    settings_used++;
    @(posedge clk_i);
  endtask

  task automatic test_reset_state();
    send_access(CMD_ROM_RD, 16'h0000, 8'h00, 0);
    send_access(CMD_ROM_RD, 16'h7FFF, 8'hFF, 0);
    send_access(CMD_ROM_RD, 16'h8000, 8'h00, 0);
    send_access(CMD_RAM_RD, 16'hFFFF, 8'h00, 0);
  endtask

  task automatic test_directed();
    apply_setting(KIND_MBC1, 512, 4, 3, 0);
    send_access(CMD_REG_WR, 16'h0000, 8'h0A, 0);
    send_access(CMD_REG_WR, 16'h2000, 8'h00, 0);
    send_access(CMD_REG_WR, 16'h4000, 8'h03, 0);
    send_access(CMD_REG_WR, 16'h6000, 8'h01, 0);
    send_access(CMD_ROM_RD, 16'h3FFF, 8'h00, 0);
    send_access(CMD_RAM_WR, 16'hA000, 8'h5A, 0);
    send_access(CMD_RAM_RD, 16'hA000, 8'h00, 0);
    apply_setting(KIND_MBC2, 16, 0, 0, 1);
    send_access(CMD_REG_WR, 16'h0000, 8'hFA, 0);
    send_access(CMD_RAM_WR, 16'hA1FF, 8'h37, 0);
    send_access(CMD_RAM_RD, 16'hA1FF, 8'h00, 0);
    apply_setting(KIND_MBC3, 1023, 31, 7, 0);
    send_access(CMD_REG_WR, 16'h0000, 8'h0A, 0);
    send_access(CMD_REG_WR, 16'h4000, 8'h08, 0);
    send_access(CMD_RAM_WR, 16'hA000, 8'h2C, 0);
    send_access(CMD_REG_WR, 16'h6000, 8'h00, 0);
    send_access(CMD_REG_WR, 16'h6000, 8'h01, 0);
    send_access(CMD_RAM_RD, 16'hA000, 8'h00, 0);
    send_access(CMD_REG_WR, 16'h4000, 8'h0D, 0);
    send_access(CMD_RAM_RD, 16'hA000, 8'h00, 0);
    apply_setting(KIND_HUC1, 0, 1, 1, 0);
    send_access(CMD_REG_WR, 16'h0000, 8'h0E, 0);
    send_access(CMD_RAM_RD, 16'hA000, 8'h00, 0);
    send_access(CMD_ROM_RD, 16'h4001, 8'h00, 0);
    apply_setting(7, 2, 0, 0, 0);
    send_access(CMD_ROM_RD, 16'h4000, 8'h00, 0);
  endtask

  task automatic test_random_traffic(int unsigned idle_pct, int unsigned rounds);
    int unsigned rom_choices[7] = '{0, 1, 2, 4, 64, 512, 1023};
    int unsigned ram_choices[6] = '{0, 1, 4, 16, 31, 2};
    int unsigned pick;
    logic [15:0] a;
    logic [7:0]  v;
    for (int r = 0; r < rounds; r++) begin
      apply_setting($urandom_range(0, 7), rom_choices[$urandom_range(0, 6)],
                    ram_choices[$urandom_range(0, 5)], $urandom_range(0, 7),
                    $urandom_range(0, 1));
      send_access(CMD_REG_WR, 16'h0000, $urandom_range(0, 1) ? 8'h0A : 8'h0E, idle_pct);
      for (int n = 0; n < 63; n++) begin
        pick = $urandom_range(0, 99);
        v = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        if (pick < 30) begin
          a = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h7FFF));
          send_access(CMD_REG_WR, a, v, idle_pct);
        end else if (pick < 50) begin
          a = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h7FFF));
          send_access(CMD_ROM_RD, a, v, idle_pct);
        end else begin
          a = ($urandom_range(0, 9) == 0) ? 16'($urandom)
            : (16'hA000 | ($urandom_range(0, 1) ? 16'($urandom_range(0, 15))
                                                 : 16'($urandom_range(0, 16'h1FFF))));
          send_access((pick < 75) ? CMD_RAM_WR : CMD_RAM_RD, a, v, idle_pct);
        end
        if ($urandom_range(0, 199) == 0) drain_words();
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed();
    test_random_traffic(29, 7);
    test_random_traffic(62, 7);
    test_random_traffic(0, 7);
    drain_words();
    $display("covered %0d words over %0d mapper settings, %0d words checked",
             words_sent, settings_used, words_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== cartridge_bank_mapper.f =====
hdl/cbm_pkg.sv
hdl/cbm_mod_unit.sv
hdl/cbm_ram.sv
hdl/cartridge_bank_mapper.sv
hdl/cbm_checker.sv
bench/testbench.sv
